// File: hw/rtl/u8gbk_pkg.sv
// Package for the UTF-8/GBK to UCS-2 decoder.
// Holds the error codes, byte thresholds and the step result type.
// No dependencies.
package u8gbk_pkg;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_LEAD = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;

  localparam logic       MODE_GBK  = 1'b0;
  localparam logic       MODE_UTF8 = 1'b1;

  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;

  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        end_of_string;
    logic [1:0]  error_code;
  } step_res_t;

endpackage

// File: hw/rtl/utf8_gbk_to_ucs2_decoder.sv
// Top level of the UTF-8/GBK to UCS-2 decoder: input register, decode core, result register.
// Depends on u8gbk_pkg and u8gbk_core.
//
// The block takes one byte per item and returns at most one 16-bit code unit per item,
// sustaining one item per clock cycle while a full result register is not held by out_ready.
// An accepted item is registered in the input register, decoded there against the held
// sequence state, and its result, if any, lands in the result register. Bytes that only
// extend a sequence produce no result. The mode register is written through cfg_valid/cfg_ready
// and should only change while the block is idle.
module utf8_gbk_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_encoding_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_end_of_string,
  output logic [1:0]  out_error_code
);

  logic                 mode_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  logic [15:0]          out_code_unit_r;
  logic                 out_eos_r;
  logic [1:0]           out_err_r;
  logic                 out_free;
  logic                 s1_advance;
  u8gbk_pkg::step_res_t res;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_ready;
  assign s1_advance = s1_valid_r && (!res.emit || out_free);
  assign in_ready   = !s1_valid_r || s1_advance;

  u8gbk_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .encoding_mode (mode_r),
    .step          (s1_advance),
    .byte_value    (s1_byte_r),
    .last_byte     (s1_last_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= u8gbk_pkg::MODE_GBK;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_encoding_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_advance && res.emit) begin
      out_code_unit_r <= res.code_unit;
      out_eos_r       <= res.end_of_string;
      out_err_r       <= res.error_code;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = out_code_unit_r;
  assign out_end_of_string = out_eos_r;
  assign out_error_code    = out_err_r;

endmodule

// File: hw/rtl/u8gbk_core.sv
// Per-byte decode logic and sequence state of the UTF-8/GBK decoder.
// Uses u8gbk_pkg for codes, thresholds and the step result type.
module u8gbk_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  encoding_mode,
  input  logic                  step,
  input  logic [7:0]            byte_value,
  input  logic                  last_byte,
  output u8gbk_pkg::step_res_t  res
);

  logic [7:0] held_lead_r, held_lead_nxt;
  logic [7:0] held_second_r, held_second_nxt;
  logic [1:0] bytes_held_r, bytes_held_nxt;
  logic [1:0] needed_total_r, needed_total_nxt;
  logic       discarding_r, discarding_nxt;

  always_comb begin
    logic clear;
    clear            = 1'b0;
    held_lead_nxt    = held_lead_r;
    held_second_nxt  = held_second_r;
    bytes_held_nxt   = bytes_held_r;
    needed_total_nxt = needed_total_r;
    discarding_nxt   = discarding_r;
    res.emit          = 1'b0;
    res.code_unit     = 16'd0;
    res.end_of_string = last_byte;
    res.error_code    = u8gbk_pkg::ERR_NONE;

    if (discarding_r) begin
      if (last_byte) begin
        res.emit       = 1'b1;
        res.error_code = u8gbk_pkg::ERR_BAD_LEAD;
        clear          = 1'b1;
      end
    end else if (bytes_held_r == 2'd0) begin
      if (!byte_value[7]) begin
        res.emit      = 1'b1;
        res.code_unit = {8'd0, byte_value};
      end else if (encoding_mode == u8gbk_pkg::MODE_GBK ||
                   byte_value <= u8gbk_pkg::LEAD2_MAX ||
                   byte_value <= u8gbk_pkg::LEAD3_MAX) begin
        if (last_byte) begin
          res.emit       = 1'b1;
          res.error_code = u8gbk_pkg::ERR_TRUNC;
          clear          = 1'b1;
        end else begin
          held_lead_nxt  = byte_value;
          bytes_held_nxt = 2'd1;
          if (encoding_mode == u8gbk_pkg::MODE_GBK || byte_value <= u8gbk_pkg::LEAD2_MAX) begin
            needed_total_nxt = u8gbk_pkg::LEN_TWO;
          end else begin
            needed_total_nxt = u8gbk_pkg::LEN_THREE;
          end
        end
      end else begin
        if (last_byte) begin
          res.emit       = 1'b1;
          res.error_code = u8gbk_pkg::ERR_BAD_LEAD;
          clear          = 1'b1;
        end else begin
          discarding_nxt = 1'b1;
        end
      end
    end else if (bytes_held_r == 2'd1 && needed_total_r == u8gbk_pkg::LEN_THREE) begin
      if (last_byte) begin
        res.emit       = 1'b1;
        res.error_code = u8gbk_pkg::ERR_TRUNC;
        clear          = 1'b1;
      end else begin
        held_second_nxt = byte_value;
        bytes_held_nxt  = 2'd2;
      end
    end else if (bytes_held_r == 2'd1) begin
      res.emit = 1'b1;
      clear    = 1'b1;
      if (encoding_mode == u8gbk_pkg::MODE_GBK) begin
        res.code_unit = {held_lead_r, byte_value};
      end else begin
        res.code_unit = {5'd0, held_lead_r[4:0], byte_value[5:0]};
      end
    end else begin
      res.emit      = 1'b1;
      clear         = 1'b1;
      res.code_unit = {held_lead_r[3:0], held_second_r[5:0], byte_value[5:0]};
    end

    if (clear) begin
      held_lead_nxt    = 8'd0;
      held_second_nxt  = 8'd0;
      bytes_held_nxt   = 2'd0;
      needed_total_nxt = 2'd0;
      discarding_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r    <= 8'd0;
      held_second_r  <= 8'd0;
      bytes_held_r   <= 2'd0;
      needed_total_r <= 2'd0;
      discarding_r   <= 1'b0;
    end else if (step) begin
      held_lead_r    <= held_lead_nxt;
      held_second_r  <= held_second_nxt;
      bytes_held_r   <= bytes_held_nxt;
      needed_total_r <= needed_total_nxt;
      discarding_r   <= discarding_nxt;
    end
  end

endmodule
